// ===== rtl/sdaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdaf_pkg;

    localparam int VALUE_W            = 32;
    localparam int CHAR_W             = 8;
    localparam int DIGIT_W            = 4;
    localparam int DEFAULT_MAX_DIGITS = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic move;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/sdaf_bcd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdaf_bcd_cell (
    input  wire                        i_clk,
    input  wire sdaf_pkg::t_cell_ctrl  i_ctrl,
    input  wire                        i_carry,
    input  wire [sdaf_pkg::DIGIT_W-1:0] i_digit,
    output logic                       o_carry,
    output logic [sdaf_pkg::DIGIT_W-1:0] o_digit
);
    import sdaf_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    always_comb begin
        adj = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    end

    always_comb begin
        priority if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {adj[DIGIT_W-2:0], i_carry};
        end else if (i_ctrl.move) begin
            n_digit = i_digit;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = adj[DIGIT_W-1];
    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ===== rtl/signed_decimal_ascii_formatter_core.sv =====
// Signed integer to decimal ASCII text.
//
// Input: a transfer takes place at a rising edge with i_start high and busy
// low; i_value is a signed 32-bit integer. The block then writes out its
// decimal text, most significant character first: '-' for a negative value,
// then the digits of the magnitude without leading zeros, a single '0' for
// zero. Each character is on o_char_code for exactly one cycle with o_valid
// high; o_last marks the final character. The receiver cannot stall, so
// every character is taken in the cycle it is shown.
//
// Sequence: the magnitude is shifted through a row of BCD digit cells, one
// bit per cycle, for all 32 bits. The sign, if any, is shown in the cycle
// after the last shift. Then the row shifts toward its top cell once per
// cycle until all MAX_DECIMAL_DIGITS digits have left it, dropping leading
// zeros; each digit is shown in the cycle after it leaves the top cell. busy
// stays high from the transfer until the last digit leaves the top cell. The
// last character is shown in the first cycle with busy low, and a new item can
// be taken at the end of that cycle.
// Reset clears the control state and the strobe; no result is pending after it.

`timescale 1ns / 1ps
`default_nettype none

module signed_decimal_ascii_formatter_core #(
    parameter int MAX_DECIMAL_DIGITS = sdaf_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire signed [sdaf_pkg::VALUE_W-1:0] i_value,
    output logic                        busy,
    output logic                        o_valid,
    output logic [sdaf_pkg::CHAR_W-1:0] o_char_code,
    output logic                        o_last
);
    import sdaf_pkg::*;

    localparam int BIT_CW = $clog2(VALUE_W);
    localparam int REM_W  = $clog2(MAX_DECIMAL_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [BIT_CW-1:0]  r_bit, n_bit;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic               r_started, n_started;
    logic               r_neg, n_neg;
    logic [VALUE_W-1:0] r_mag, n_mag;
    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;

    t_cell_ctrl         ctrl;
    logic [VALUE_W-1:0] raw;
    logic [DIGIT_W-1:0] top_digit;

    logic [MAX_DECIMAL_DIGITS-1:0] carry;
    logic [DIGIT_W-1:0]            digit [MAX_DECIMAL_DIGITS];

    assign raw       = i_value;
    assign top_digit = digit[MAX_DECIMAL_DIGITS-1];

    always_comb begin
        n_state   = r_state;
        n_bit     = r_bit;
        n_rem     = r_rem;
        n_started = r_started;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_valid   = 1'b0;
        n_char    = r_char;
        n_last    = 1'b0;
        ctrl      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    ctrl.clear = 1'b1;
                    n_neg      = raw[VALUE_W-1];
                    n_mag      = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
                    n_bit      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                ctrl.dabble = 1'b1;
                n_mag       = {r_mag[VALUE_W-2:0], 1'b0};
                n_bit       = r_bit + 1'b1;
                if (r_bit == BIT_CW'(VALUE_W - 1)) begin
                    n_rem     = REM_W'(MAX_DECIMAL_DIGITS);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                    if (r_neg) begin
                        n_valid = 1'b1;
                        n_char  = CHAR_MINUS;
                    end
                end
            end
            S_EMIT: begin
                ctrl.move = 1'b1;
                n_rem     = r_rem - 1'b1;
                if (r_started || top_digit != '0 || r_rem == REM_W'(1)) begin
                    n_valid   = 1'b1;
                    n_started = 1'b1;
                    n_char    = CHAR_ZERO + CHAR_W'(top_digit);
                    n_last    = (r_rem == REM_W'(1));
                end
                if (r_rem == REM_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_rem     <= n_rem;
        r_started <= n_started;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_char    <= n_char;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_DECIMAL_DIGITS; g++) begin : g_cell
            logic               cin;
            logic [DIGIT_W-1:0] din;
            if (g == 0) begin : g_first
                assign cin = r_mag[VALUE_W-1];
                assign din = '0;
            end else begin : g_rest
                assign cin = carry[g-1];
                assign din = digit[g-1];
            end
            sdaf_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_carry (cin),
                .i_digit (din),
                .o_carry (carry[g]),
                .o_digit (digit[g])
            );
        end
    endgenerate

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// ===== rtl/sdaf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdaf_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_start,
    input wire                          busy,
    input wire                          o_valid,
    input wire [sdaf_pkg::CHAR_W-1:0]   o_char_code,
    input wire                          o_last
);
    import sdaf_pkg::*;

    // A transfer always starts work.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CHAR_MINUS) ||
                    (o_char_code >= CHAR_ZERO && o_char_code <= CHAR_NINE))
        else $error("character outside sign and digit set");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_char_code == CHAR_MINUS |-> !o_last)
        else $error("sign marked as final character");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("character directly after final character");

    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_valid |-> o_last)
        else $error("non-final character while idle");

endmodule

bind signed_decimal_ascii_formatter_core sdaf_checker u_sdaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);

`default_nettype wire

// ===== tb/sv/signed_decimal_ascii_formatter_core_checker.sv =====
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter_core_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire                                 busy,
    input  wire [sdaf_pkg::VALUE_W-1:0]         i_value,
    input  wire                                 o_valid,
    input  wire [sdaf_pkg::CHAR_W-1:0]          o_char_code,
    input  wire                                 o_last,
    output int                                  error_count,
    output int                                  pending_count
);

    typedef struct {
        logic [sdaf_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    t_text_char expected_text[$];
    int         mismatches;

    initial begin
        error_count   = 0;
        pending_count = 0;
        mismatches    = 0;
    end

    function automatic void push_char(logic [sdaf_pkg::CHAR_W-1:0] code, logic last);
        t_text_char c;
        c.code = code;
        c.last = last;
        expected_text.push_back(c);
    endfunction

    // Writes the decimal text of one signed value into the expected queue.
    function automatic void queue_decimal_text(logic [sdaf_pkg::VALUE_W-1:0] value);
        logic [sdaf_pkg::VALUE_W-1:0] magnitude;
        logic [3:0]                   digit_buf [10];
        logic                         negative;
        int                           ndigits;
        negative  = value[sdaf_pkg::VALUE_W-1];
        magnitude = negative ? (~value + 1'b1) : value;
        ndigits   = 0;
        if (magnitude == '0) begin
            push_char(sdaf_pkg::CHAR_ZERO, 1'b1);
            return;
        end
        while (magnitude != '0) begin
            digit_buf[ndigits] = 4'(magnitude % 10);
            magnitude          = magnitude / 10;
            ndigits++;
        end
        if (negative) begin
            push_char(sdaf_pkg::CHAR_MINUS, 1'b0);
        end
        for (int j = ndigits - 1; j >= 0; j--) begin
            push_char(sdaf_pkg::CHAR_ZERO + 8'(digit_buf[j]), j == 0);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_text.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected character: code %0d last %0b",
                                 o_char_code, o_last);
                    end
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    if (o_char_code !== want.code || o_last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("Mismatch: expected code %0d last %0b, got code %0d last %0b",
                                     want.code, want.last, o_char_code, o_last);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_start && !busy) begin
                queue_decimal_text(i_value);
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_text.size();
    end

endmodule

// ===== tb/sv/signed_decimal_ascii_formatter_core_tb.sv =====
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter_core_tb;

    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_ITEMS   = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic [sdaf_pkg::VALUE_W-1:0]  i_value;
    logic                          busy;
    logic                          o_valid;
    logic [sdaf_pkg::CHAR_W-1:0]   o_char_code;
    logic                          o_last;
    int                            error_count;
    int                            pending_count;
    int                            cycle_count;

    logic [sdaf_pkg::VALUE_W-1:0]  directed_values [20];

    signed_decimal_ascii_formatter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_value     (i_value),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    signed_decimal_ascii_formatter_core_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .busy          (busy),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_char_code   (o_char_code),
        .o_last        (o_last),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[signed_decimal_ascii_formatter_core] ERROR");
            $finish;
        end
    end

    // Holds i_start high until the block takes the value in a transfer.
    task automatic send_value(logic [sdaf_pkg::VALUE_W-1:0] value);
        i_start <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_burst();
        i_start <= 1'b0;
        i_value <= $urandom;
        if ($urandom_range(1, 0) == 1) begin
            do @(posedge i_clk); while (busy);
        end
        repeat ($urandom_range(6, 1)) @(posedge i_clk);
    endtask

    // In three of four draws picks a digit count first, each equally likely.
    function automatic logic [sdaf_pkg::VALUE_W-1:0] random_value();
        logic [sdaf_pkg::VALUE_W-1:0] magnitude;
        longint                       lower;
        longint                       upper;
        int                           ndigits;
        logic                         negative;
        if ($urandom_range(3, 0) == 0) begin
            return $urandom;
        end
        ndigits = $urandom_range(10, 1);
        lower   = 1;
        repeat (ndigits - 1) lower = lower * 10;
        upper = lower * 10 - 1;
        if (upper > 64'd2147483648) begin
            upper = 64'd2147483648;
        end
        if (ndigits == 1) begin
            lower = 0;
        end
        magnitude = $urandom_range(upper[31:0], lower[31:0]);
        negative  = 1'($urandom_range(1, 0));
        if (!negative && magnitude == 32'h8000_0000) begin
            magnitude = 32'h7fff_ffff;
        end
        return negative ? (~magnitude + 1'b1) : magnitude;
    endfunction

    initial begin
        directed_values = '{
            32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            -32'sd101, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
            32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1234567890,
            -32'sd5, 32'h5555_5555, 32'haaaa_aaaa
        };
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_value = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[k]) begin
            send_value(directed_values[k]);
            if ($urandom_range(2, 0) == 0) begin
                idle_burst();
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_value(random_value());
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(9, 0) < 3) begin
                idle_burst();
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (error_count == 0 && pending_count == 0) begin
            $display("[signed_decimal_ascii_formatter_core] OK");
        end else begin
            $display("[signed_decimal_ascii_formatter_core] ERROR");
        end
        $finish;
    end

endmodule
